// ===== rtl/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants of the HTTP body deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

   localparam int COUNT_BITS = 32;
   localparam int LINE_BITS  = 17;
   localparam int MAX_LINE_W = 16;
   localparam int CLEN_W     = 32;
   localparam int MODE_W     = 2;
   localparam int BYTE_W     = 8;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [MAX_LINE_W-1:0] RESET_MAX_LINE = 16'd16384;

   localparam logic ACT_BEGIN = 1'b0;
   localparam logic ACT_BYTE  = 1'b1;

   localparam logic [MODE_W-1:0] MODE_CONTENT_LEN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHUNKED     = 2'd1;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_CRLF = 3'd1,
      ERR_LONG = 3'd2,
      ERR_IDLE = 3'd3,
      ERR_OVF  = 3'd4
   } err_type;

endpackage

`default_nettype wire

// ===== rtl/http_body_deframer_core.sv =====
// ----------------------------------------------------------------------------
// http_body_deframer_core
// HTTP/1.1 response body deframer: content-length, chunked and until-close.
// ----------------------------------------------------------------------------
// Path: a transaction passes the input register, then the per-byte state
//   update, then the result register; a stall on the response holds both.
// Throughput: one transaction per cycle unless the response stream stalls;
//   the per-byte state update is one pass of logic between the two registers.
// Reset: synchronous, clears all control state; max_line_len returns to 16384.
`default_nettype none

module http_body_deframer_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // config
   input  wire logic                            csr_wr_en,
   input  wire logic [hbd_pkg::MAX_LINE_W-1:0] csr_wr_data,   // max_line_len
   // request stream
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [hbd_pkg::REQ_DATA_W-1:0] req_tdata,     // framing_mode, body_len, data_byte
   input  wire logic                            req_tuser,     // action
   // response stream
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [hbd_pkg::RSP_DATA_W-1:0] rsp_tdata,     // payload_byte, error_code, zero pad
   output      logic                            rsp_tuser,     // payload_valid
   output      logic                            rsp_tlast      // response_done
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CL,
      PH_SIZE,
      PH_DATA,
      PH_CRLF,
      PH_TRAIL,
      PH_EOF
   } phase_type;

   localparam int CB = hbd_pkg::COUNT_BITS;
   localparam int LB = hbd_pkg::LINE_BITS;

   // registers
   logic [hbd_pkg::MAX_LINE_W-1:0] max_line_ff;
   logic                           in_valid_ff;
   logic [hbd_pkg::REQ_DATA_W-1:0] in_data_ff;
   logic                           in_user_ff;
   phase_type                      phase_ff, phase_in;
   logic [CB-1:0]                  bytes_left_ff, bytes_left_in;
   logic                           hex_ended_ff, hex_ended_in;
   logic [LB-1:0]                  line_count_ff, line_count_in;
   logic                           first_cr_ff, first_cr_in;
   logic                           rsp_valid_ff;
   logic [hbd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                           rsp_user_ff, rsp_user_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic advance;
   logic fire;

   // unpacked input fields
   logic [hbd_pkg::MODE_W-1:0] in_mode;
   logic [hbd_pkg::CLEN_W-1:0] in_clen;
   logic [hbd_pkg::BYTE_W-1:0] in_byte;

   // per-item results
   logic                       pv;
   logic [hbd_pkg::BYTE_W-1:0] pb;
   logic                       done;
   hbd_pkg::err_type           err;
   logic [LB-1:0]              lc_inc;
   logic                       line_ok;
   logic                       hex_ok;
   logic [3:0]                 hex_val;
   logic [CB-1:0]              bytes_dec;

   assign in_mode = in_data_ff[hbd_pkg::MODE_W-1:0];
   assign in_clen = in_data_ff[hbd_pkg::MODE_W +: hbd_pkg::CLEN_W];
   assign in_byte = in_data_ff[hbd_pkg::MODE_W + hbd_pkg::CLEN_W +: hbd_pkg::BYTE_W];

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= "0" && in_byte <= "9") begin
         hex_val = 4'(in_byte - "0");
      end else if (in_byte >= "a" && in_byte <= "f") begin
         hex_val = 4'(in_byte - "a" + 8'd10);
      end else if (in_byte >= "A" && in_byte <= "F") begin
         hex_val = 4'(in_byte - "A" + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign lc_inc    = (line_count_ff != {LB{1'b1}}) ? line_count_ff + 1'b1 : line_count_ff;
   assign line_ok   = lc_inc <= {{(LB-hbd_pkg::MAX_LINE_W){1'b0}}, max_line_ff};
   assign bytes_dec = bytes_left_ff - 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      hex_ended_in  = hex_ended_ff;
      line_count_in = line_count_ff;
      first_cr_in   = first_cr_ff;
      pv            = 1'b0;
      pb            = '0;
      done          = 1'b0;
      err           = hbd_pkg::ERR_NONE;

      if (in_user_ff == hbd_pkg::ACT_BEGIN) begin
         phase_in      = PH_IDLE;
         bytes_left_in = '0;
         hex_ended_in  = 1'b0;
         line_count_in = '0;
         first_cr_in   = 1'b0;
         unique case (in_mode)
            hbd_pkg::MODE_CONTENT_LEN: begin
               if ((in_clen >> CB) != '0) begin
                  err = hbd_pkg::ERR_OVF;
               end else if (in_clen == '0) begin
                  done = 1'b1;
               end else begin
                  phase_in      = PH_CL;
                  bytes_left_in = CB'(in_clen);
               end
            end
            hbd_pkg::MODE_CHUNKED: phase_in = PH_SIZE;
            default:               phase_in = PH_EOF;
         endcase
      end else begin
         unique case (phase_ff)
            PH_CL: begin
               pv            = 1'b1;
               pb            = in_byte;
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            end
            PH_EOF: begin
               pv = 1'b1;
               pb = in_byte;
            end
            PH_SIZE: begin
               if (in_byte == hbd_pkg::CHAR_LF) begin
                  phase_in      = (bytes_left_ff != '0) ? PH_DATA : PH_TRAIL;
                  hex_ended_in  = 1'b0;
                  line_count_in = '0;
                  first_cr_in   = 1'b0;
               end else if (!line_ok) begin
                  err = hbd_pkg::ERR_LONG;
               end else begin
                  line_count_in = lc_inc;
                  if (!hex_ended_ff) begin
                     if (!hex_ok) begin
                        hex_ended_in = 1'b1;
                     end else if (bytes_left_ff[CB-1 -: 4] != 4'd0) begin
                        err = hbd_pkg::ERR_OVF;
                     end else begin
                        bytes_left_in = {bytes_left_ff[CB-5:0], hex_val};
                     end
                  end
               end
            end
            PH_DATA: begin
               pv            = 1'b1;
               pb            = in_byte;
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  phase_in    = PH_CRLF;
                  first_cr_in = 1'b0;
               end
            end
            PH_CRLF: begin
               if (!first_cr_ff) begin
                  if (in_byte == hbd_pkg::CHAR_CR) begin
                     first_cr_in = 1'b1;
                  end else begin
                     err = hbd_pkg::ERR_CRLF;
                  end
               end else if (in_byte == hbd_pkg::CHAR_LF) begin
                  phase_in      = PH_SIZE;
                  first_cr_in   = 1'b0;
                  line_count_in = '0;
                  hex_ended_in  = 1'b0;
                  bytes_left_in = '0;
               end else begin
                  err = hbd_pkg::ERR_CRLF;
               end
            end
            PH_TRAIL: begin
               if (in_byte == hbd_pkg::CHAR_LF) begin
                  if (line_count_ff == '0 ||
                      (line_count_ff == LB'(1) && first_cr_ff)) begin
                     phase_in      = PH_IDLE;
                     bytes_left_in = '0;
                     hex_ended_in  = 1'b0;
                     line_count_in = '0;
                     first_cr_in   = 1'b0;
                     done          = 1'b1;
                  end else begin
                     line_count_in = '0;
                     first_cr_in   = 1'b0;
                  end
               end else begin
                  if (line_count_ff == '0) begin
                     first_cr_in = (in_byte == hbd_pkg::CHAR_CR);
                  end
                  line_count_in = lc_inc;
                  if (!line_ok) begin
                     err = hbd_pkg::ERR_LONG;
                  end
               end
            end
            default: err = hbd_pkg::ERR_IDLE;
         endcase

         if (err != hbd_pkg::ERR_NONE) begin
            phase_in      = PH_IDLE;
            bytes_left_in = '0;
            hex_ended_in  = 1'b0;
            line_count_in = '0;
            first_cr_in   = 1'b0;
            pv            = 1'b0;
            pb            = '0;
            done          = 1'b0;
         end
      end

      rsp_data_in = {{(hbd_pkg::RSP_DATA_W - hbd_pkg::BYTE_W - 3){1'b0}}, err, pb};
      rsp_user_in = pv;
      rsp_last_in = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff   <= hbd_pkg::RESET_MAX_LINE;
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         hex_ended_ff  <= 1'b0;
         line_count_ff <= '0;
         first_cr_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_line_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            hex_ended_ff  <= hex_ended_in;
            line_count_ff <= line_count_in;
            first_cr_ff   <= first_cr_in;
         end
      end
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hbd_checker.sv =====
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks on the result stream of the body deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [hbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser,
   input wire logic                            rsp_tlast
);

   logic [2:0] err_code;
   logic [7:0] pay_byte;

   assign pay_byte = rsp_tdata[7:0];
   assign err_code = rsp_tdata[10:8];

   a_err_clears_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (err_code != hbd_pkg::ERR_NONE) |-> !rsp_tuser && !rsp_tlast)
      else $error("error result carries payload or done");

   a_no_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> pay_byte == 8'd0)
      else $error("payload byte nonzero without payload_valid");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> err_code <= hbd_pkg::ERR_OVF)
      else $error("error code out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind http_body_deframer_core hbd_checker u_hbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_body_deframer_core. Drives begin and byte
// transactions (content-length, chunked, until-close bodies, broken framing
// and noise) under random stalls on both streams. A scoreboard predicts each
// response and compares it in order with what the core returns, across
// several line-length limits.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hbd_pkg::*;

   localparam logic [MODE_W-1:0] MODE_TO_CLOSE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;

   class deframer_scoreboard;
      typedef enum logic [2:0] {
         ST_IDLE, ST_CLEN, ST_SIZE, ST_DATA, ST_CRLF, ST_TRAIL, ST_EOF
      } body_phase_type;

      typedef struct packed {
         logic        pv;
         logic [7:0]  pb;
         logic        done;
         err_type     err;
      } body_result_type;

      logic [MAX_LINE_W-1:0] line_limit;
      body_phase_type        phase;
      logic [COUNT_BITS-1:0] bytes_left;
      bit                    hex_ended;
      logic [LINE_BITS-1:0]  line_count;
      bit                    first_cr;
      body_result_type       expected_q[$];
      int                    mismatches;

      function new();
         line_limit = RESET_MAX_LINE;
         mismatches = 0;
         restart_body();
      endfunction

      function void restart_body();
         phase      = ST_IDLE;
         bytes_left = '0;
         hex_ended  = 0;
         line_count = '0;
         first_cr   = 0;
      endfunction

      function int hex_digit(logic [7:0] b);
         if (b >= "0" && b <= "9") return int'(b - "0");
         if (b >= "a" && b <= "f") return int'(b - "a") + 10;
         if (b >= "A" && b <= "F") return int'(b - "A") + 10;
         return -1;
      endfunction

      function bit line_fits();
         if (line_count != '1) line_count++;
         return line_count <= {1'b0, line_limit};
      endfunction

      function void note_request(logic act, logic [MODE_W-1:0] mode,
                                 logic [CLEN_W-1:0] clen, logic [7:0] b);
         body_result_type r;
         int d;
         r = '0;
         r.err = ERR_NONE;
         if (act == ACT_BEGIN) begin
            restart_body();
            if (mode == MODE_CONTENT_LEN) begin
               if ((clen >> COUNT_BITS) != 0) begin
                  r.err = ERR_OVF;
               end else if (clen == 0) begin
                  r.done = 1'b1;
               end else begin
                  phase = ST_CLEN;
                  bytes_left = COUNT_BITS'(clen);
               end
            end else if (mode == MODE_CHUNKED) begin
               phase = ST_SIZE;
            end else begin
               phase = ST_EOF;
            end
         end else begin
            case (phase)
               ST_CLEN: begin
                  r.pv = 1'b1;
                  r.pb = b;
                  bytes_left--;
                  if (bytes_left == 0) begin
                     restart_body();
                     r.done = 1'b1;
                  end
               end
               ST_EOF: begin
                  r.pv = 1'b1;
                  r.pb = b;
               end
               ST_SIZE: begin
                  if (b == CHAR_LF) begin
                     phase = (bytes_left != 0) ? ST_DATA : ST_TRAIL;
                     hex_ended = 0;
                     line_count = '0;
                     first_cr = 0;
                  end else if (!line_fits()) begin
                     r.err = ERR_LONG;
                  end else if (!hex_ended) begin
                     d = hex_digit(b);
                     if (d < 0) begin
                        hex_ended = 1;
                     end else if (bytes_left[COUNT_BITS-1 -: 4] != 0) begin
                        r.err = ERR_OVF;
                     end else begin
                        bytes_left = {bytes_left[COUNT_BITS-5:0], 4'(d)};
                     end
                  end
               end
               ST_DATA: begin
                  r.pv = 1'b1;
                  r.pb = b;
                  bytes_left--;
                  if (bytes_left == 0) begin
                     phase = ST_CRLF;
                     first_cr = 0;
                  end
               end
               ST_CRLF: begin
                  if (!first_cr) begin
                     if (b == CHAR_CR) first_cr = 1;
                     else r.err = ERR_CRLF;
                  end else if (b == CHAR_LF) begin
                     phase = ST_SIZE;
                     first_cr = 0;
                     line_count = '0;
                     hex_ended = 0;
                     bytes_left = '0;
                  end else begin
                     r.err = ERR_CRLF;
                  end
               end
               ST_TRAIL: begin
                  if (b == CHAR_LF) begin
                     if (line_count == 0 || (line_count == 1 && first_cr)) begin
                        restart_body();
                        r.done = 1'b1;
                     end else begin
                        line_count = '0;
                        first_cr = 0;
                     end
                  end else begin
                     if (line_count == 0) first_cr = (b == CHAR_CR);
                     if (!line_fits()) r.err = ERR_LONG;
                  end
               end
               default: r.err = ERR_IDLE;
            endcase
            if (r.err != ERR_NONE) begin
               restart_body();
               r.pv = 1'b0;
               r.pb = '0;
               r.done = 1'b0;
            end
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(logic pv, logic [7:0] pb, logic done,
                                   logic [2:0] err);
         body_result_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing expected: ",
                        $realtime,
                        "pv=%0b pb=%02h done=%0b err=%0d", pv, pb, done, err);
            return;
         end
         e = expected_q.pop_front();
         if (e.pv !== pv || e.pb !== pb || e.done !== done || e.err !== err) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp pv=%0b pb=%02h done=%0b err=%0d, ",
                        $realtime, e.pv, e.pb, e.done, e.err,
                        "got pv=%0b pb=%02h done=%0b err=%0d", pv, pb, done, err);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [MAX_LINE_W-1:0] csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   deframer_scoreboard sb;
   int  items_sent;
   int  cycle_count = 0;
   bit  sender_calm;
   bit  receiver_calm;
   int  hold_asked;
   int  hold_taken = 0;
   int  hold_left = 0;

   http_body_deframer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: check, then pick next tready
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[10:8]);
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (receiver_calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic send_item(input logic act, input logic [MODE_W-1:0] mode,
                            input logic [CLEN_W-1:0] clen, input logic [7:0] b);
      while (!sender_calm && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, b, clen, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, mode, clen, b);
      items_sent++;
   endtask

   task automatic send_begin(input logic [MODE_W-1:0] mode, input logic [CLEN_W-1:0] clen);
      send_item(ACT_BEGIN, mode, clen, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(ACT_BYTE, 2'($urandom), $urandom, b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic end_line(input bit bare_lf_ok);
      if (!bare_lf_ok || $urandom_range(3) != 0) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   task automatic write_line_limit(input logic [MAX_LINE_W-1:0] v);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.line_limit = v;
   endtask

   task automatic run_chunked_body();
      int    chunks;
      int    n;
      int    lines;
      string s;
      chunks = $urandom_range(0, 3);
      send_begin(MODE_CHUNKED, $urandom);
      for (int c = 0; c < chunks; c++) begin
         if ($urandom_range(19) == 0) begin
            // nine digits: overflows the size counter unless the line limit ends it first
            s = $sformatf("%0h%08h", $urandom_range(1, 15), $urandom);
            if ($urandom_range(1)) s = s.toupper();
            send_text(s);
            return;
         end
         n = $urandom_range(1, 24);
         s = $sformatf("%0h", n);
         if ($urandom_range(1)) s = s.toupper();
         if ($urandom_range(3) == 0) s = {"00", s};
         send_text(s);
         if ($urandom_range(3) == 0) send_text(";ext=v");
         end_line(1);
         repeat (n) send_byte(8'($urandom));
         if ($urandom_range(14) == 0) begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end else begin
            end_line(0);
         end
      end
      if ($urandom_range(4) != 0) send_text($urandom_range(1) ? "0" : "000");
      if ($urandom_range(3) == 0) send_text(";last");
      end_line(1);
      lines = $urandom_range(0, 2);
      for (int l = 0; l < lines; l++) begin
         n = $urandom_range(1, 10);
         repeat (n) send_byte(8'($urandom_range(32, 126)));
         end_line(1);
      end
      end_line(1);
   endtask

   task automatic run_random_body();
      int kind;
      int n;
      logic [CLEN_W-1:0] clen;
      kind = $urandom_range(99);
      if (kind < 45) begin
         run_chunked_body();
      end else if (kind < 75) begin
         clen = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 20);
         send_begin(MODE_CONTENT_LEN, clen);
         n = (clen > 20) ? $urandom_range(1, 8) : int'(clen);
         if ($urandom_range(7) == 0) n = $urandom_range(0, n + 2);
         repeat (n) send_byte(8'($urandom));
      end else if (kind < 88) begin
         send_begin($urandom_range(1) ? MODE_TO_CLOSE : MODE_RESERVED, $urandom);
         repeat ($urandom_range(1, 15)) send_byte(8'($urandom));
      end else if (kind < 96) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
         send_begin(2'($urandom), $urandom);
      end
   endtask

   task automatic run_random_phase(input int count, input bit calm);
      int stop_at;
      stop_at = items_sent + count;
      sender_calm = calm;
      receiver_calm = calm;
      while (items_sent < stop_at) run_random_body();
      sender_calm = 0;
      receiver_calm = 0;
   endtask

   initial begin
      sb = new();
      items_sent = 0;
      sender_calm = 0;
      receiver_calm = 0;
      hold_asked = 0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= ACT_BEGIN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_byte("A");
      send_begin(MODE_CONTENT_LEN, 0);
      send_begin(MODE_CONTENT_LEN, 2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_begin(MODE_TO_CLOSE, '1);
      send_byte(8'h55);
      send_begin(MODE_RESERVED, '0);
      send_byte(8'hAA);
      send_begin(MODE_CHUNKED, 32'h5A5A_A5A5);
      send_text("1;");
      end_line(0);
      send_byte(8'h7E);
      end_line(0);
      send_text("0");
      end_line(0);
      send_text("X");
      end_line(0);
      end_line(0);

      run_random_phase(250, 0);

      write_line_limit(16'hFFFF);
      hold_asked++;
      run_random_phase(150, 1);

      write_line_limit(16'd1);
      run_random_phase(80, 0);

      write_line_limit(16'd0);
      run_random_phase(60, 0);

      write_line_limit(16'($urandom_range(3, 12)));
      run_random_phase(130, 1);
      run_random_phase(130, 0);

      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
